[hdl/heavy_hitter_sketch_update_defines.svh]
// Assertion macros for the sketch update block.
`ifndef HEAVY_HITTER_SKETCH_UPDATE_DEFINES_SVH
`define HEAVY_HITTER_SKETCH_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HHS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sketch update: implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sketch update: next-cycle check failed");

`endif

[hdl/hhs_pkg.sv]
`default_nettype none

package hhs_pkg;

    localparam int KEY_W = 104;

    localparam logic [31:0] SEED_BASE  = 32'd1324534127;
    localparam logic [31:0] SEED_STEP  = 32'd6156137;
    localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2     = 32'h1b873593;
    localparam logic [31:0] ROUND_ADD  = 32'he6546b64;
    localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;
    localparam logic [31:0] HASH_LEN   = 32'd13;
    localparam logic [30:0] LCG_MUL    = 31'd1103515245;
    localparam logic [30:0] LCG_INC    = 31'd12345;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFFFFFF;
    localparam logic [7:0]  RUN_MAX    = 8'd255;

    localparam logic [1:0] LAST_ROUND    = 2'd2;
    localparam logic [2:0] LAST_MOD_STEP = 3'd7;
    localparam int         MOD_BITS      = 4;

    typedef enum logic [1:0] {
        ACT_CLAIMED  = 2'd0,
        ACT_MATCHED  = 2'd1,
        ACT_REPLACED = 2'd2,
        ACT_KEPT     = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MIX1,
        F_MIX2,
        F_ROUND,
        F_FIN0,
        F_FIN1,
        F_FIN2,
        F_FIN3,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_EVAL,
        B_THR,
        B_OUT
    } back_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

`default_nettype wire

[hdl/heavy_hitter_sketch_update.sv]
// Heavy-hitter sketch update.
// Input channel: one flow key per transaction (src_addr, dst_addr, src_port,
// dst_port, protocol), taken when in_valid is high and in_stall is low.
// Output channel: ROWS result transactions per key in row order, the final
// one flagged by last, taken when out_valid is high and out_stall is low.
// random_seed_we loads the random generator state from random_seed.
// A front hash sequencer computes the bucket of each row (two mix steps,
// then per row: three rounds, four finalization steps, eight steps of
// column reduction at four bits a cycle, one hand-off step) and
// hands rows to the back unit through a two-entry queue. The back unit does
// one bucket read-modify-write a row.
// The front takes the next key only after it has handed off the last row of
// the current key and gone back to idle.
// Reset clears control state and starts a pass that zeroes the bucket state
// memory; in_stall stays high during it.
// A stalled output holds its result; the back unit then waits, the queue
// fills, and the front and in_stall back up behind it.
`default_nettype none

`include "heavy_hitter_sketch_update_defines.svh"

module heavy_hitter_sketch_update #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        random_seed_we,
    input  wire logic [30:0] random_seed,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] src_addr,
    input  wire logic [31:0] dst_addr,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [7:0]  protocol,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       row_index,
    output logic [9:0]       column_index,
    output logic [1:0]       action,
    output logic [31:0]      bucket_count,
    output logic [7:0]       longest_run,
    output logic [7:0]       current_run,
    output logic             last
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(COLUMNS);
    localparam int AW = $clog2(ROWS * COLUMNS);
    localparam int QW = 1 + RW + CW + AW + hhs_pkg::KEY_W;

    logic                      clearing;
    logic                      push;
    logic                      q_full;
    logic                      pop;
    logic                      head_valid;
    logic [QW-1:0]             head_data;
    logic [hhs_pkg::KEY_W-1:0] push_key;
    logic [AW-1:0]             push_addr;
    logic [RW-1:0]             push_row;
    logic [CW-1:0]             push_col;
    logic                      push_last;

    hhs_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr),
        .src_port  (src_port),
        .dst_port  (dst_port),
        .protocol  (protocol),
        .q_full    (q_full),
        .push      (push),
        .push_key  (push_key),
        .push_addr (push_addr),
        .push_row  (push_row),
        .push_col  (push_col),
        .push_last (push_last)
    );

    hhs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_last, push_row, push_col, push_addr, push_key}),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    hhs_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .random_seed_we (random_seed_we),
        .random_seed    (random_seed),
        .clearing       (clearing),
        .head_valid     (head_valid),
        .pop            (pop),
        .head_key       (head_data[hhs_pkg::KEY_W-1:0]),
        .head_addr      (head_data[hhs_pkg::KEY_W +: AW]),
        .head_row       (head_data[hhs_pkg::KEY_W + AW + CW +: RW]),
        .head_col       (head_data[hhs_pkg::KEY_W + AW +: CW]),
        .head_last      (head_data[QW-1]),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_index      (row_index),
        .column_index   (column_index),
        .action         (action),
        .bucket_count   (bucket_count),
        .longest_run    (longest_run),
        .current_run    (current_run),
        .last           (last)
    );

    `HHS_ASSERT_IMPLY(a_no_accept_in_clear, in_valid && !in_stall, !clearing)
    `HHS_ASSERT_NEXT(a_front_busy_after_accept, in_valid && !in_stall, in_stall)
    `HHS_ASSERT_IMPLY(a_count_nonzero, out_valid, bucket_count != 32'd0)
    `HHS_ASSERT_IMPLY(a_claim_fresh,
        out_valid && (action == hhs_pkg::ACT_CLAIMED),
        (bucket_count == 32'd1) && (longest_run == 8'd1) && (current_run == 8'd1))
    `HHS_ASSERT_IMPLY(a_kept_run_cleared, out_valid && (action == hhs_pkg::ACT_KEPT), current_run == 8'd0)

endmodule

`default_nettype wire

[hdl/hhs_front.sv]
`default_nettype none

module hhs_front #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              clearing,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [31:0]                       src_addr,
    input  wire logic [31:0]                       dst_addr,
    input  wire logic [15:0]                       src_port,
    input  wire logic [15:0]                       dst_port,
    input  wire logic [7:0]                        protocol,
    input  wire logic                              q_full,
    output logic                                   push,
    output logic [hhs_pkg::KEY_W-1:0]              push_key,
    output logic [$clog2(ROWS*COLUMNS)-1:0]        push_addr,
    output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] push_row,
    output logic [$clog2(COLUMNS)-1:0]             push_col,
    output logic                                   push_last
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(COLUMNS);
    localparam int MW = CW + 1;
    localparam int AW = $clog2(ROWS * COLUMNS);

    hhs_pkg::front_state_t state_reg, state_next;

    logic [hhs_pkg::KEY_W-1:0] key_reg;
    logic [31:0]               kb_reg [4];
    logic [31:0]               h_reg;
    logic [31:0]               seed_reg;
    logic [RW-1:0]             row_reg;
    logic [1:0]                rnd_reg;
    logic [2:0]                mod_reg;
    logic [CW-1:0]             rem_reg;
    logic                      accept;
    logic                      last_row;
    logic [CW-1:0]             rem_next;
    logic [31:0]               round_h;
    logic [31:0]               fin0_h;
    logic [31:0]               fin2_t;

    assign last_row = (row_reg == RW'(ROWS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hhs_pkg::F_IDLE:  if (in_valid && !clearing) state_next = hhs_pkg::F_MIX1;
            hhs_pkg::F_MIX1:  state_next = hhs_pkg::F_MIX2;
            hhs_pkg::F_MIX2:  state_next = hhs_pkg::F_ROUND;
            hhs_pkg::F_ROUND: if (rnd_reg == hhs_pkg::LAST_ROUND) state_next = hhs_pkg::F_FIN0;
            hhs_pkg::F_FIN0:  state_next = hhs_pkg::F_FIN1;
            hhs_pkg::F_FIN1:  state_next = hhs_pkg::F_FIN2;
            hhs_pkg::F_FIN2:  state_next = hhs_pkg::F_FIN3;
            hhs_pkg::F_FIN3:  state_next = hhs_pkg::F_MOD;
            hhs_pkg::F_MOD:   if (mod_reg == hhs_pkg::LAST_MOD_STEP) state_next = hhs_pkg::F_PUSH;
            hhs_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = last_row ? hhs_pkg::F_IDLE : hhs_pkg::F_ROUND;
                end
            end
            default:          state_next = hhs_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = !((state_reg == hhs_pkg::F_IDLE) && !clearing);
        push     = (state_reg == hhs_pkg::F_PUSH) && !q_full;
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        logic [MW-1:0] r;
        logic [CW-1:0] c;
        c = rem_reg;
        for (int i = 0; i < hhs_pkg::MOD_BITS; i++)
        begin
            r = {c, h_reg[31 - i]};
            if (r >= MW'(COLUMNS))
            begin
                r = r - MW'(COLUMNS);
            end
            c = CW'(r);
        end
        rem_next = c;
    end

    assign round_h = (hhs_pkg::rotl32(h_reg ^ kb_reg[rnd_reg], 13) * 32'd5) + hhs_pkg::ROUND_ADD;
    assign fin0_h  = h_reg ^ kb_reg[3] ^ hhs_pkg::HASH_LEN;
    assign fin2_t  = h_reg ^ (h_reg >> 13);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhs_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            hhs_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    key_reg   <= {src_addr, dst_addr, src_port, dst_port, protocol};
                    kb_reg[0] <= hhs_pkg::bswap32(src_addr);
                    kb_reg[1] <= hhs_pkg::bswap32(dst_addr);
                    kb_reg[2] <= {dst_port[7:0], dst_port[15:8], src_port[7:0], src_port[15:8]};
                    kb_reg[3] <= {24'd0, protocol};
                end
            end
            hhs_pkg::F_MIX1:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    kb_reg[i] <= hhs_pkg::rotl32(kb_reg[i] * hhs_pkg::MIX_C1, 15);
                end
            end
            hhs_pkg::F_MIX2:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    kb_reg[i] <= kb_reg[i] * hhs_pkg::MIX_C2;
                end
                seed_reg <= hhs_pkg::SEED_BASE;
                h_reg    <= hhs_pkg::SEED_BASE;
                row_reg  <= '0;
                rnd_reg  <= '0;
            end
            hhs_pkg::F_ROUND:
            begin
                h_reg   <= round_h;
                rnd_reg <= rnd_reg + 2'd1;
            end
            hhs_pkg::F_FIN0: h_reg <= fin0_h ^ (fin0_h >> 16);
            hhs_pkg::F_FIN1: h_reg <= h_reg * hhs_pkg::FMIX_C1;
            hhs_pkg::F_FIN2: h_reg <= fin2_t * hhs_pkg::FMIX_C2;
            hhs_pkg::F_FIN3:
            begin
                h_reg   <= h_reg ^ (h_reg >> 16);
                rem_reg <= '0;
                mod_reg <= '0;
            end
            hhs_pkg::F_MOD:
            begin
                rem_reg <= rem_next;
                h_reg   <= h_reg << hhs_pkg::MOD_BITS;
                mod_reg <= mod_reg + 3'd1;
            end
            hhs_pkg::F_PUSH:
            begin
                if (!q_full && !last_row)
                begin
                    row_reg  <= row_reg + RW'(1);
                    seed_reg <= seed_reg + hhs_pkg::SEED_STEP;
                    h_reg    <= seed_reg + hhs_pkg::SEED_STEP;
                    rnd_reg  <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign push_key  = key_reg;
    assign push_row  = row_reg;
    assign push_col  = rem_reg;
    assign push_last = last_row;
    assign push_addr = AW'(32'(row_reg) * 32'(COLUMNS) + 32'(rem_reg));

endmodule

`default_nettype wire

[hdl/hhs_queue.sv]
`default_nettype none

module hhs_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       fill_reg;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_data  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/hhs_back.sv]
`default_nettype none

module hhs_back #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              random_seed_we,
    input  wire logic [30:0]                       random_seed,
    output logic                                   clearing,
    input  wire logic                              head_valid,
    output logic                                   pop,
    input  wire logic [hhs_pkg::KEY_W-1:0]         head_key,
    input  wire logic [$clog2(ROWS*COLUMNS)-1:0]   head_addr,
    input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] head_row,
    input  wire logic [$clog2(COLUMNS)-1:0]        head_col,
    input  wire logic                              head_last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             row_index,
    output logic [9:0]                             column_index,
    output logic [1:0]                             action,
    output logic [31:0]                            bucket_count,
    output logic [7:0]                             longest_run,
    output logic [7:0]                             current_run,
    output logic                                   last
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(ROWS * COLUMNS);
    localparam int DEPTH = ROWS * COLUMNS;

    hhs_pkg::back_state_t state_reg, state_next;

    logic [hhs_pkg::KEY_W-1:0] key_mem   [DEPTH];
    logic [47:0]               state_mem [DEPTH];
    logic [hhs_pkg::KEY_W-1:0] key_rdata_reg;
    logic [47:0]               state_rdata_reg;

    logic [AW-1:0]             clear_addr_reg;
    logic [hhs_pkg::KEY_W-1:0] key_reg;
    logic [AW-1:0]             addr_reg;
    logic [RW-1:0]             row_reg;
    logic [CW-1:0]             col_reg;
    logic                      last_reg;
    logic [31:0]               cnt_reg;
    logic [7:0]                lr_reg;
    logic [7:0]                cr_reg;
    hhs_pkg::action_t          act_reg;
    logic [39:0]               den_reg;
    logic [30:0]               rand_reg;
    logic                      out_valid_reg;

    logic [31:0]               rd_cnt;
    logic [7:0]                rd_lr;
    logic [7:0]                rd_cr;
    logic                      is_empty;
    logic                      is_match;
    logic [30:0]               rand_step;
    logic [31:0]               rv_plus;
    logic [63:0]               thr_prod;
    logic                      do_replace;
    logic                      out_free;
    logic                      state_we;
    logic [AW-1:0]             state_waddr;
    logic [47:0]               state_wdata;
    logic                      key_we;
    logic [31:0]               fin_cnt;
    logic [7:0]                fin_lr;
    logic [7:0]                fin_cr;
    logic [7:0]                cr_inc;

    assign rd_cnt    = state_rdata_reg[47:16];
    assign rd_lr     = state_rdata_reg[15:8];
    assign rd_cr     = state_rdata_reg[7:0];
    assign is_empty  = (rd_cnt == 32'd0);
    assign is_match  = (key_rdata_reg == key_reg);
    assign rand_step = rand_reg * hhs_pkg::LCG_MUL + hhs_pkg::LCG_INC;
    assign rv_plus   = {1'b0, rand_reg} + 32'd1;
    assign thr_prod  = rv_plus * den_reg[31:0];
    assign do_replace = (den_reg == 40'd0) ||
                        ((den_reg[39:32] == 8'd0) && (thr_prod[63:32] == 32'd0));
    assign out_free  = !out_valid_reg || !out_stall;
    assign cr_inc    = cr_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hhs_pkg::B_CLEAR: if (clear_addr_reg == AW'(DEPTH - 1)) state_next = hhs_pkg::B_IDLE;
            hhs_pkg::B_IDLE:  if (head_valid) state_next = hhs_pkg::B_EVAL;
            hhs_pkg::B_EVAL:
            begin
                if (!is_empty && !is_match)
                begin
                    state_next = hhs_pkg::B_THR;
                end
                else
                begin
                    state_next = hhs_pkg::B_OUT;
                end
            end
            hhs_pkg::B_THR:   state_next = hhs_pkg::B_OUT;
            hhs_pkg::B_OUT:   if (out_free) state_next = hhs_pkg::B_IDLE;
            default:          state_next = hhs_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        fin_cnt = cnt_reg;
        fin_lr  = lr_reg;
        fin_cr  = cr_reg;
        key_we  = 1'b0;
        case (act_reg)
            hhs_pkg::ACT_CLAIMED:
            begin
                fin_cnt = 32'd1;
                fin_lr  = 8'd1;
                fin_cr  = 8'd1;
                key_we  = 1'b1;
            end
            hhs_pkg::ACT_MATCHED:
            begin
                if (cnt_reg != hhs_pkg::COUNT_MAX)
                begin
                    fin_cnt = cnt_reg + 32'd1;
                end
                if (cr_reg != hhs_pkg::RUN_MAX)
                begin
                    fin_cr = cr_inc;
                    if (lr_reg < cr_inc)
                    begin
                        fin_lr = cr_inc;
                    end
                end
            end
            hhs_pkg::ACT_REPLACED:
            begin
                fin_lr = 8'd1;
                fin_cr = 8'd1;
                key_we = 1'b1;
            end
            default:
            begin
                fin_cr = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        clearing    = (state_reg == hhs_pkg::B_CLEAR);
        pop         = (state_reg == hhs_pkg::B_IDLE) && head_valid;
        state_we    = clearing || ((state_reg == hhs_pkg::B_OUT) && out_free);
        state_waddr = clearing ? clear_addr_reg : addr_reg;
        state_wdata = clearing ? 48'd0 : {fin_cnt, fin_lr, fin_cr};
    end

    always_ff @(posedge clk)
    begin
        if (state_we)
        begin
            state_mem[state_waddr] <= state_wdata;
        end
        state_rdata_reg <= state_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == hhs_pkg::B_OUT) && out_free && key_we)
        begin
            key_mem[addr_reg] <= key_reg;
        end
        key_rdata_reg <= key_mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hhs_pkg::B_CLEAR;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
            rand_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (random_seed_we)
            begin
                rand_reg <= random_seed;
            end
            else if ((state_reg == hhs_pkg::B_EVAL) && !is_empty && !is_match)
            begin
                rand_reg <= rand_step;
            end
            if ((state_reg == hhs_pkg::B_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            key_reg  <= head_key;
            addr_reg <= head_addr;
            row_reg  <= head_row;
            col_reg  <= head_col;
            last_reg <= head_last;
        end
        if (state_reg == hhs_pkg::B_EVAL)
        begin
            cnt_reg <= rd_cnt;
            lr_reg  <= rd_lr;
            cr_reg  <= rd_cr;
            den_reg <= rd_cnt * {32'd0, rd_lr};
            if (is_empty)
            begin
                act_reg <= hhs_pkg::ACT_CLAIMED;
            end
            else if (is_match)
            begin
                act_reg <= hhs_pkg::ACT_MATCHED;
            end
            else
            begin
                act_reg <= hhs_pkg::ACT_KEPT;
            end
        end
        if ((state_reg == hhs_pkg::B_THR) && do_replace)
        begin
            act_reg <= hhs_pkg::ACT_REPLACED;
        end
        if ((state_reg == hhs_pkg::B_OUT) && out_free)
        begin
            row_index    <= 2'(row_reg);
            column_index <= 10'(col_reg);
            action       <= act_reg;
            bucket_count <= fin_cnt;
            longest_run  <= fin_lr;
            current_run  <= fin_cr;
            last         <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[bench/heavy_hitter_sketch_update_tb.sv]
`timescale 1ns / 1ps

module heavy_hitter_sketch_update_tb;

    localparam int NROWS = 4;
    localparam int NCOLS = 1024;

    typedef logic [103:0] flow_key_t;

    typedef struct packed {
        logic [1:0]       row;
        logic [9:0]       col;
        hhs_pkg::action_t act;
        logic [31:0]      cnt;
        logic [7:0]       lng;
        logic [7:0]       cur;
        logic             lst;
    } bucket_update_t;

    function automatic logic [31:0] scramble_word(logic [31:0] w);
        w = w * hhs_pkg::MIX_C1;
        w = {w[16:0], w[31:17]};
        return w * hhs_pkg::MIX_C2;
    endfunction

    function automatic logic [31:0] flow_hash(flow_key_t k, logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] chunk;
        h = seed;
        for (int b = 0; b < 3; b++)
        begin
            chunk = k[103 - 32 * b -: 32];
            h ^= scramble_word({chunk[7:0], chunk[15:8], chunk[23:16], chunk[31:24]});
            h = {h[18:0], h[31:19]};
            h = h * 32'd5 + hhs_pkg::ROUND_ADD;
        end
        h ^= scramble_word({24'd0, k[7:0]});
        h ^= hhs_pkg::HASH_LEN;
        h ^= h >> 16;
        h *= hhs_pkg::FMIX_C1;
        h ^= h >> 13;
        h *= hhs_pkg::FMIX_C2;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic logic [9:0] flow_column(flow_key_t k, int r);
        return 10'(flow_hash(k, hhs_pkg::SEED_BASE + hhs_pkg::SEED_STEP * r) % NCOLS);
    endfunction

    class sketch_scoreboard;
        flow_key_t   keys[NROWS * NCOLS];
        logic [31:0] counts[NROWS * NCOLS];
        logic [7:0]  longest[NROWS * NCOLS];
        logic [7:0]  current[NROWS * NCOLS];
        logic [30:0] lcg_state;
        bucket_update_t pending_updates[$];
        int errors;
        int checked;
        int per_action[4];

        function new();
            for (int i = 0; i < NROWS * NCOLS; i++)
            begin
                counts[i] = '0;
                longest[i] = '0;
                current[i] = '0;
            end
            lcg_state = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void load_seed(logic [30:0] v);
            lcg_state = v;
        endfunction

        function void note_input(flow_key_t k);
            bucket_update_t u;
            int idx;
            logic [63:0] den;
            for (int r = 0; r < NROWS; r++)
            begin
                u.row = 2'(r);
                u.col = flow_column(k, r);
                idx = r * NCOLS + u.col;
                if (counts[idx] == 32'd0)
                begin
                    keys[idx] = k;
                    counts[idx] = 32'd1;
                    longest[idx] = 8'd1;
                    current[idx] = 8'd1;
                    u.act = hhs_pkg::ACT_CLAIMED;
                end
                else if (keys[idx] == k)
                begin
                    if (counts[idx] != hhs_pkg::COUNT_MAX)
                        counts[idx]++;
                    if (current[idx] < hhs_pkg::RUN_MAX)
                    begin
                        current[idx]++;
                        if (longest[idx] < current[idx])
                            longest[idx] = current[idx];
                    end
                    u.act = hhs_pkg::ACT_MATCHED;
                end
                else
                begin
                    current[idx] = 8'd0;
                    lcg_state = lcg_state * hhs_pkg::LCG_MUL + hhs_pkg::LCG_INC;
                    den = 64'(counts[idx]) * 64'(longest[idx]);
                    if (den == 64'd0)
                        den = 64'd1;
                    if (64'(lcg_state) < 64'hFFFF_FFFF / den)
                    begin
                        keys[idx] = k;
                        longest[idx] = 8'd1;
                        current[idx] = 8'd1;
                        u.act = hhs_pkg::ACT_REPLACED;
                    end
                    else
                        u.act = hhs_pkg::ACT_KEPT;
                end
                u.cnt = counts[idx];
                u.lng = longest[idx];
                u.cur = current[idx];
                u.lst = (r == NROWS - 1);
                pending_updates.push_back(u);
            end
        endfunction

        function void compare_field(string name, longint e, longint a);
            if (e != a)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(bucket_update_t a);
            bucket_update_t e;
            if (pending_updates.size() == 0)
            begin
                $display("%0t: unexpected result transaction, actual %p", $time, a);
                errors++;
                return;
            end
            e = pending_updates.pop_front();
            checked++;
            per_action[e.act]++;
            compare_field("row_index", e.row, a.row);
            compare_field("column_index", e.col, a.col);
            compare_field("action", e.act, a.act);
            compare_field("bucket_count", e.cnt, a.cnt);
            compare_field("longest_run", e.lng, a.lng);
            compare_field("current_run", e.cur, a.cur);
            compare_field("last", e.lst, a.lst);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        random_seed_we = 1'b0;
    logic [30:0] random_seed = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] src_addr = '0;
    logic [31:0] dst_addr = '0;
    logic [15:0] src_port = '0;
    logic [15:0] dst_port = '0;
    logic [7:0]  protocol = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  row_index;
    logic [9:0]  column_index;
    logic [1:0]  action;
    logic [31:0] bucket_count;
    logic [7:0]  longest_run;
    logic [7:0]  current_run;
    logic        last;

    bit quiet = 0;
    int sent = 0;
    sketch_scoreboard board = new();

    heavy_hitter_sketch_update u_top (
        .clk(clk), .rst_n(rst_n),
        .random_seed_we(random_seed_we), .random_seed(random_seed),
        .in_valid(in_valid), .in_stall(in_stall),
        .src_addr(src_addr), .dst_addr(dst_addr),
        .src_port(src_port), .dst_port(dst_port), .protocol(protocol),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_index(row_index), .column_index(column_index), .action(action),
        .bucket_count(bucket_count), .longest_run(longest_run),
        .current_run(current_run), .last(last)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result({row_index, column_index, hhs_pkg::action_t'(action),
                                bucket_count, longest_run, current_run, last});
    end

    initial
    begin
        int len;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic flow_key_t random_key();
        return {$urandom(), $urandom(), $urandom(), 8'($urandom())};
    endfunction

    // Search for a different key landing in the same row-0 bucket.
    function automatic flow_key_t colliding_key(flow_key_t k);
        flow_key_t c;
        logic [9:0] target;
        target = flow_column(k, 0);
        do
            c = random_key();
        while (flow_column(c, 0) != target || c == k);
        return c;
    endfunction

    task automatic send_key(flow_key_t k);
        bit stalled;
        in_valid <= 1'b1;
        src_addr <= k[103:72];
        dst_addr <= k[71:40];
        src_port <= k[39:24];
        dst_port <= k[23:8];
        protocol <= k[7:0];
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        board.note_input(k);
        sent++;
        if (!quiet && $urandom_range(0, 9) < 3)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (board.pending_updates.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_seed(logic [30:0] v);
        drain();
        random_seed_we <= 1'b1;
        random_seed <= v;
        @(posedge clk);
        board.load_seed(v);
        random_seed_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(int n, int quiet_tail);
        flow_key_t hot[8];
        flow_key_t prev;
        flow_key_t k;
        int pick;
        foreach (hot[i])
            hot[i] = random_key();
        prev = hot[0];
        for (int i = 0; i < n; i++)
        begin
            if (i == n - quiet_tail)
                quiet = 1;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                k = prev;
            else if (pick < 55)
                k = hot[$urandom_range(0, 7)];
            else if (pick < 80)
                k = colliding_key(hot[$urandom_range(0, 7)]);
            else
                k = random_key();
            send_key(k);
            prev = k;
        end
    endtask

    initial
    begin
        flow_key_t a;
        flow_key_t b;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_seed('0);
        a = '1;
        send_key('0);
        send_key(a);
        send_key('0);
        send_key(a);
        send_key(a);
        send_key({13{8'hAA}});
        send_key({13{8'h55}});
        b = colliding_key(a);
        send_key(b);
        send_key(b);
        send_key(a);
        send_key(colliding_key(a));
        send_key(a);
        send_key({32'h8000_0001, 32'h0000_FFFF, 16'hFFFF, 16'h0000, 8'h80});
        send_key({32'h7FFF_FFFE, 32'hFFFF_0000, 16'h0000, 16'hFFFF, 8'h01});

        write_seed(31'h7FFF_FFFF);
        random_traffic(120, 0);

        write_seed(31'($urandom()));
        random_traffic(126, 40);

        drain();
        $display("Sent %0d flow keys, checked %0d bucket updates", sent, board.checked);
        $display("Updates by kind: claimed %0d, matched %0d, replaced %0d, kept %0d",
                 board.per_action[hhs_pkg::ACT_CLAIMED],
                 board.per_action[hhs_pkg::ACT_MATCHED],
                 board.per_action[hhs_pkg::ACT_REPLACED],
                 board.per_action[hhs_pkg::ACT_KEPT]);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/hhs_pkg.sv
hdl/hhs_front.sv
hdl/hhs_queue.sv
hdl/hhs_back.sv
hdl/heavy_hitter_sketch_update.sv
bench/heavy_hitter_sketch_update_tb.sv
